@@ rtl/core/ocrm_pkg.sv @@
`default_nettype none

package ocrm_pkg;

    // Fixed field widths
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned TYPF_W    = 31;
    localparam int unsigned QUO_W     = 32;
    localparam int unsigned NUM_W     = 2 * QUO_W;

    // Default number of fraction bits
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Reset value of the typical function magnitude register
    localparam logic [TYPF_W-1:0] TYPF_RESET = 31'd65536;

    // Mode select codes
    localparam logic FUNC_GRAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Input word
    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] base_x;
        logic signed [DATA_W-1:0] other_value;
        logic signed [DATA_W-1:0] typical_x;
        logic signed [DATA_W-1:0] func_value;
        logic                     last_element;
    } ocrm_in_t;

    // Output word
    typedef struct packed {
        logic [QUO_W-1:0] max_ratio;
        logic             saturated;
    } ocrm_out_t;

    // Operand stage control
    typedef struct packed {
        logic load_mag;
        logic load_num;
    } ocrm_opnd_ctrl_t;

    // Divider status
    typedef struct packed {
        logic done;
        logic sat;
    } ocrm_div_status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_EMIT
    } ocrm_state_t;

    // Absolute value of a signed word; the most negative value maps to 2^31
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage : ocrm_pkg

`default_nettype wire

@@ rtl/core/ocrm_operand.sv @@
`default_nettype none

module ocrm_operand
    import ocrm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic            clk,
    input  wire ocrm_opnd_ctrl_t ctrl,
    input  wire ocrm_in_t        word,
    input  wire logic [TYPF_W-1:0] typical_f,
    output logic [NUM_W-1:0]     num,
    output logic [QUO_W-1:0]     den
);

    logic              func_reg;
    logic [DATA_W-1:0] mag_a_reg;
    logic [DATA_W-1:0] mag_b_reg;
    logic [DATA_W-1:0] diff_reg;
    logic [QUO_W-1:0]  den_reg;
    logic [NUM_W-1:0]  num_reg;

    logic [DATA_W-1:0] mag_bx;
    logic [DATA_W-1:0] mag_ov;
    logic [DATA_W-1:0] mag_tx;
    logic [DATA_W-1:0] mag_fv;
    logic [DATA_W-1:0] typf_ext;
    logic [DATA_W:0]   diff_s;
    logic [DATA_W:0]   diff_mag;
    logic [DATA_W-1:0] den_grad;
    logic [DATA_W-1:0] den_step;
    logic [NUM_W-1:0]  prod;
    logic [NUM_W-1:0]  shifted;

    // Form magnitudes, the step difference and both candidate divisors
    always_comb
    begin
        mag_bx   = mag32(word.base_x);
        mag_ov   = mag32(word.other_value);
        mag_tx   = mag32(word.typical_x);
        mag_fv   = mag32(word.func_value);
        typf_ext = {1'b0, typical_f};
        diff_s   = {word.other_value[DATA_W-1], word.other_value}
                 - {word.base_x[DATA_W-1], word.base_x};
        diff_mag = diff_s[DATA_W] ? (~diff_s + 1'b1) : diff_s;
        den_grad = (mag_fv > typf_ext) ? mag_fv : typf_ext;
        den_step = (mag_ov > mag_tx) ? mag_ov : mag_tx;
    end

    // Hold magnitudes for the multiply cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.load_mag)
        begin
            func_reg  <= word.func;
            mag_a_reg <= (mag_bx > mag_tx) ? mag_bx : mag_tx;
            mag_b_reg <= mag_ov;
            diff_reg  <= diff_mag[DATA_W-1:0];
            den_reg   <= (word.func == FUNC_STEP) ? den_step : den_grad;
        end
    end

    // Product for the gradient term, scaled difference for the step term
    always_comb
    begin
        prod    = NUM_W'(mag_a_reg) * NUM_W'(mag_b_reg);
        shifted = NUM_W'(diff_reg) << FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_num)
        begin
            num_reg <= (func_reg == FUNC_STEP) ? shifted : prod;
        end
    end

    assign num = num_reg;
    assign den = den_reg;

endmodule : ocrm_operand

`default_nettype wire

@@ rtl/core/ocrm_div.sv @@
`default_nettype none

module ocrm_div
    import ocrm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [QUO_W-1:0] den,
    output ocrm_div_status_t      status,
    output logic [QUO_W-1:0]      quotient
);

    localparam int unsigned CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             sat_reg;
    logic             sat_next;
    logic [QUO_W-1:0] rem_reg;
    logic [QUO_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;

    logic [QUO_W:0]   trial;
    logic [QUO_W:0]   diff;
    logic             ge;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        diff  = trial - {1'b0, den};
        ge    = trial >= {1'b0, den};
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            // Zero divisor or quotient beyond 32 bits: saturate at once
            if (den == '0 || num[NUM_W-1:QUO_W] >= den)
            begin
                sat_next = 1'b1;
                quo_next = '1;
                cnt_next = '0;
            end
            else
            begin
                sat_next = 1'b0;
                rem_next = num[NUM_W-1:QUO_W];
                quo_next = num[QUO_W-1:0];
                cnt_next = CNT_W'(QUO_W);
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rem_next = ge ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign status.done = busy_reg && (cnt_reg == '0);
    assign status.sat  = sat_reg;
    assign quotient    = quo_reg;

endmodule : ocrm_div

`default_nettype wire

@@ rtl/core/optimizer_convergence_ratio_max.sv @@
`default_nettype none

// Channel   Direction  Handshake                Word
// in        input      in_valid / in_stall      ocrm_in_t
// out       output     out_valid / out_stall    ocrm_out_t
// cfg       input      cfg_write_en             cfg_write_data (typical_f)
//
// Each word passes these steps from acceptance to acceptance: magnitudes, the
// 32x32 multiply, the divider load with its zero and overflow check, 32
// quotient bits, the done check and the return to idle; a saturating word
// skips the quotient bits. A last word also passes an emit step into the output
// register, held while that register holds an untaken word; in_stall is high all along.
// Reset clears the running maximum and sticky flag and sets typical_f to 65536.
module optimizer_convergence_ratio_max
    import ocrm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ocrm_in_t          in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ocrm_out_t              out_word,
    input  wire logic              cfg_write_en,
    input  wire logic [TYPF_W-1:0] cfg_write_data
);

    ocrm_state_t      state_reg;
    ocrm_state_t      state_next;

    ocrm_in_t         word_reg;
    logic [TYPF_W-1:0] typf_reg;
    logic [QUO_W-1:0] run_max_reg;
    logic [QUO_W-1:0] run_max_next;
    logic             sticky_reg;
    logic             sticky_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    ocrm_out_t        out_word_reg;
    ocrm_out_t        out_word_next;

    ocrm_opnd_ctrl_t  opnd_ctrl;
    logic             div_start;
    ocrm_div_status_t div_status;
    logic [NUM_W-1:0] num;
    logic [QUO_W-1:0] den;
    logic [QUO_W-1:0] quotient;

    logic             accept;
    logic             out_free;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Operand formation: magnitudes, then product or scaled step
    ocrm_operand #(
        .FRAC_BITS (FRAC_BITS)
    ) u_operand (
        .clk       (clk),
        .ctrl      (opnd_ctrl),
        .word      (word_reg),
        .typical_f (typf_reg),
        .num       (num),
        .den       (den)
    );

    // Shared iterative divider
    ocrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num),
        .den      (den),
        .status   (div_status),
        .quotient (quotient)
    );

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= in_word;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            typf_reg <= TYPF_RESET;
        end
        else if (cfg_write_en)
        begin
            typf_reg <= cfg_write_data;
        end
    end

    // Sequencer: next state, unit controls, running max and output register
    always_comb
    begin
        state_next     = state_reg;
        in_stall       = 1'b1;
        opnd_ctrl      = '0;
        div_start      = 1'b0;
        run_max_next   = run_max_reg;
        sticky_next    = sticky_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                opnd_ctrl.load_mag = 1'b1;
                state_next         = ST_MUL;
            end
            ST_MUL:
            begin
                opnd_ctrl.load_num = 1'b1;
                state_next         = ST_START;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    if (quotient > run_max_reg)
                    begin
                        run_max_next = quotient;
                    end
                    if (div_status.sat)
                    begin
                        sticky_next = 1'b1;
                    end
                    state_next = word_reg.last_element ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // Hand off the vector result once the output register frees up
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.max_ratio = run_max_reg;
                    out_word_next.saturated = sticky_reg;
                    run_max_next            = '0;
                    sticky_next             = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_max_reg   <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_max_reg   <= run_max_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule : optimizer_convergence_ratio_max

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb
    import ocrm_pkg::*;
();

    localparam int          FRAC        = FRAC_BITS_DEF;
    localparam int          ITEM_CYCLES = 48;
    localparam int          HOLD_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic             sat;
        logic [QUO_W-1:0] ratio;
    } term_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    ocrm_in_t          in_word;
    logic              out_valid;
    logic              out_stall;
    ocrm_out_t         out_word;
    logic              cfg_write_en;
    logic [TYPF_W-1:0] cfg_write_data;

    // Predictor state: register copy and per-vector accumulation
    logic [TYPF_W-1:0] typf_model;
    logic [QUO_W-1:0]  vec_max;
    logic              vec_sat;
    ocrm_out_t         pending_maxima[$];

    bit          idle_on;
    bit          hold_request;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    optimizer_convergence_ratio_max u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_word       (out_word),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #10 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] mag64(input logic signed [DATA_W-1:0] v);
        longint signed s;
        s = v;
        return (s < 0) ? -s : s;
    endfunction

    // Ratio of one element under the current typical_f, saturated to 32 bits
    function automatic term_t element_ratio(input ocrm_in_t w);
        logic [63:0]    num;
        logic [63:0]    den;
        logic [63:0]    quo;
        logic [63:0]    alt;
        longint signed  diff;
        term_t          t;
        if (w.func == FUNC_GRAD)
        begin
            num = mag64(w.base_x);
            alt = mag64(w.typical_x);
            if (alt > num) num = alt;
            num = num * mag64(w.other_value);
            den = mag64(w.func_value);
            if (64'(typf_model) > den) den = 64'(typf_model);
        end
        else
        begin
            diff = longint'($signed(w.other_value)) - longint'($signed(w.base_x));
            num  = 64'((diff < 0) ? -diff : diff) << FRAC;
            den  = mag64(w.other_value);
            alt  = mag64(w.typical_x);
            if (alt > den) den = alt;
        end
        if (den == '0)
        begin
            t.sat   = 1'b1;
            t.ratio = '1;
        end
        else
        begin
            quo = num / den;
            if (quo > 64'hFFFF_FFFF)
            begin
                t.sat   = 1'b1;
                t.ratio = '1;
            end
            else
            begin
                t.sat   = 1'b0;
                t.ratio = quo[QUO_W-1:0];
            end
        end
        return t;
    endfunction

    function automatic ocrm_in_t elem(input logic f,
                                      input logic signed [DATA_W-1:0] bx,
                                      input logic signed [DATA_W-1:0] ov,
                                      input logic signed [DATA_W-1:0] tx,
                                      input logic signed [DATA_W-1:0] fv,
                                      input logic last);
        ocrm_in_t w;
        w.func         = f;
        w.base_x       = bx;
        w.other_value  = ov;
        w.typical_x    = tx;
        w.func_value   = fv;
        w.last_element = last;
        return w;
    endfunction

    // Mix of extremes, small values, values near 1.0 and full-range noise
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3:       return r[0] ? Q_ONE : -Q_ONE;
            4, 5:    return {{11{r[31]}}, r[20:0]};
            6, 7:    return {{15{r[31]}}, r[16:0]};
            default: return r;
        endcase
    endfunction

    function automatic ocrm_in_t random_element(input logic last);
        ocrm_in_t    w;
        logic [31:0] r;
        w = elem(1'($urandom_range(0, 1)), pick_value(), pick_value(), pick_value(),
                 pick_value(), last);
        // keep half of the steps short so the ratio stays in range
        if (w.func == FUNC_STEP && $urandom_range(0, 1) == 1)
        begin
            r = $urandom;
            w.other_value = w.base_x + {{20{r[31]}}, r[11:0]};
        end
        return w;
    endfunction

    // Offer one word, wait for acceptance, fold it into the prediction
    task automatic send_element(input ocrm_in_t w);
        term_t       t;
        ocrm_out_t   expd;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        t = element_ratio(w);
        if (t.ratio > vec_max) vec_max = t.ratio;
        vec_sat = vec_sat | t.sat;
        if (w.last_element)
        begin
            expd.max_ratio = vec_max;
            expd.saturated = vec_sat;
            pending_maxima.push_back(expd);
            vec_max = '0;
            vec_sat = 1'b0;
        end
    endtask

    // Drop valid and wait until the block has gone idle
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_maxima.size() != 0) @(posedge clk);
        repeat (ITEM_CYCLES) @(posedge clk);
    endtask

    task automatic set_typical_f(input logic [TYPF_W-1:0] v);
        wait_quiet();
        cfg_write_data <= v;
        cfg_write_en   <= 1'b1;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        typf_model = v;
    endtask

    task automatic send_random_vectors(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
            for (int k = 1; k <= len; k++)
                send_element(random_element(k == len));
            sent += len;
        end
    endtask

    task automatic test_directed();
        // plain gradient and step terms
        send_element(elem(FUNC_GRAD, 2 * Q_ONE, 3 * Q_ONE, Q_ONE, 4 * Q_ONE, 1'b1));
        send_element(elem(FUNC_STEP, Q_ONE, Q_ONE + Q_ONE / 2, Q_ONE / 2, '0, 1'b1));
        send_element(elem(FUNC_STEP, 2 * Q_ONE, -2 * Q_ONE, Q_ONE, Q_MAX, 1'b1));
        // most negative input everywhere
        send_element(elem(FUNC_GRAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
        send_element(elem(FUNC_STEP, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
        // widest step difference
        send_element(elem(FUNC_STEP, Q_MAX, Q_MIN, '0, Q_MIN, 1'b1));
        // zero divisor in step mode
        send_element(elem(FUNC_STEP, 3 * Q_ONE, '0, '0, Q_ONE, 1'b1));
        send_element(elem(FUNC_STEP, '0, '0, '0, '0, 1'b1));
        // quotient too large in gradient mode
        send_element(elem(FUNC_GRAD, Q_MAX, Q_MAX, '0, '0, 1'b1));
        // zero gradient, and a small negative f below the floor
        send_element(elem(FUNC_GRAD, Q_MAX, '0, Q_MAX, Q_MAX, 1'b1));
        send_element(elem(FUNC_GRAD, Q_ONE, Q_ONE, '0, -Q_ONE / 2, 1'b1));
        // maximum inside the vector, not on its last element
        send_element(elem(FUNC_GRAD, Q_ONE, Q_ONE / 4, '0, Q_ONE, 1'b0));
        send_element(elem(FUNC_GRAD, Q_ONE, 2 * Q_ONE, '0, Q_ONE, 1'b0));
        send_element(elem(FUNC_STEP, Q_ONE, Q_ONE / 2, Q_ONE, '0, 1'b0));
        send_element(elem(FUNC_GRAD, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1));
        // saturation early in a vector, then a clean vector after it
        send_element(elem(FUNC_STEP, Q_ONE, '0, '0, '0, 1'b0));
        send_element(elem(FUNC_GRAD, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0));
        send_element(elem(FUNC_GRAD, -Q_ONE, Q_ONE / 8, '0, Q_ONE, 1'b1));
        send_element(elem(FUNC_GRAD, Q_ONE, Q_ONE / 8, '0, Q_ONE, 1'b0));
        send_element(elem(FUNC_STEP, Q_ONE, Q_ONE, Q_ONE, '0, 1'b1));
    endtask

    task automatic test_config_extremes();
        // floor of zero: f equal to zero divides by zero
        set_typical_f('0);
        send_element(elem(FUNC_GRAD, Q_ONE, Q_ONE, Q_ONE, '0, 1'b1));
        send_element(elem(FUNC_GRAD, Q_ONE, 3 * Q_ONE, '0, 2 * Q_ONE, 1'b1));
        send_element(elem(FUNC_GRAD, Q_MIN, Q_MIN, '0, 32'sd1, 1'b1));
        // largest floor
        set_typical_f('1);
        send_element(elem(FUNC_GRAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
        send_element(elem(FUNC_GRAD, Q_MAX, Q_ONE, '0, '0, 1'b1));
        send_random_vectors(30);
        set_typical_f(TYPF_RESET);
    endtask

    task automatic test_backpressure();
        // hold the output long enough to back the block up into its input
        wait_quiet();
        hold_request = 1'b1;
        for (int k = 0; k < 10; k++)
            send_element(random_element(1'b1));
        // pause the sender until every result is back
        wait_quiet();
    endtask

    task automatic test_random_phases();
        set_typical_f(TYPF_RESET);
        send_random_vectors(120);
        set_typical_f(TYPF_W'($urandom_range(1, 32'h0100_0000)));
        send_random_vectors(120);
        set_typical_f(TYPF_W'($urandom));
        send_random_vectors(120);
        set_typical_f(TYPF_W'($urandom_range(0, 255)));
        send_random_vectors(120);
    endtask

    task automatic test_streaming();
        set_typical_f(TYPF_RESET);
        idle_on = 1'b0;
        send_random_vectors(140);
    endtask

    // Output side: random stall bursts, plus one long hold on request
    initial
    begin : receiver
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each taken word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        ocrm_out_t expd;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_maxima.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: max_ratio %h saturated %b",
                             out_word.max_ratio, out_word.saturated);
            end
            else
            begin
                expd = pending_maxima.pop_front();
                if (out_word.max_ratio !== expd.max_ratio
                    || out_word.saturated !== expd.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: max_ratio exp %h got %h, saturated exp %b got %b",
                                 expd.max_ratio, out_word.max_ratio,
                                 expd.saturated, out_word.saturated);
                end
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_word        <= '0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        hold_request   = 1'b0;
        idle_on        = 1'b1;
        typf_model     = TYPF_RESET;
        vec_max        = '0;
        vec_sat        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_phases();
        test_streaming();

        wait_quiet();
        if (mismatches == 0 && pending_maxima.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
